[hdl/q24_pkg.sv]
// ----------------------------------------------------------------------------
// q24_pkg
// Shared types, opcodes and defaults for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package q24_pkg;

   localparam int FracBitsDefault = 8;
   localparam int WordBitsDefault = 32;
   localparam int FuncBits        = 4;
   localparam int FieldBits       = 32;

   localparam logic [FuncBits-1:0] FUNC_ADD      = 4'd0;
   localparam logic [FuncBits-1:0] FUNC_SUB      = 4'd1;
   localparam logic [FuncBits-1:0] FUNC_MUL      = 4'd2;
   localparam logic [FuncBits-1:0] FUNC_DIV      = 4'd3;
   localparam logic [FuncBits-1:0] FUNC_MIN      = 4'd4;
   localparam logic [FuncBits-1:0] FUNC_MAX      = 4'd5;
   localparam logic [FuncBits-1:0] FUNC_INC      = 4'd6;
   localparam logic [FuncBits-1:0] FUNC_DEC      = 4'd7;
   localparam logic [FuncBits-1:0] FUNC_TO_INT   = 4'd8;
   localparam logic [FuncBits-1:0] FUNC_FROM_INT = 4'd9;

   typedef struct packed {
      logic [FuncBits-1:0]         func;
      logic signed [FieldBits-1:0] operand_a;
      logic signed [FieldBits-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [FieldBits-1:0] result;
      logic                        is_less;
      logic                        is_equal;
      logic                        is_greater;
      logic                        overflow;
      logic                        divide_by_zero;
   } rsp_type;

endpackage

[hdl/q24_req_if.sv]
// ----------------------------------------------------------------------------
// q24_req_if
// Valid/ready channel carrying one ALU request item.
// ----------------------------------------------------------------------------
interface q24_req_if;
   logic             valid;
   logic             ready;
   q24_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/q24_rsp_if.sv]
// ----------------------------------------------------------------------------
// q24_rsp_if
// Valid/ready channel carrying one ALU result item.
// ----------------------------------------------------------------------------
interface q24_rsp_if;
   logic             valid;
   logic             ready;
   q24_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/q24_8_fixed_point_alu.sv]
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Pipelined signed fixed-point ALU with saturation and compare flags.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one item = func, operand_a, operand_b; accepted on
//   req.valid && req.ready. rsp channel: one result item per request, in
//   order, accepted on rsp.valid && rsp.ready.
//   Pipeline: stage 0 decodes operands and magnitudes, then the divider
//   runs one quotient bit per stage (WORD_BITS+FRAC_BITS+1 stages), and
//   the multiply is cut into four 16x16-bit partial products summed over
//   two stages. Two final stages round and sign, then saturate.
//   Throughput: one item per cycle while rsp does not stall.
//   The whole pipe advances only when its last stage is empty or taken, so
//   a stall on rsp holds every stage and nothing is lost or repeated; with
//   a stall, req.ready falls at once.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu #(
   parameter int FRAC_BITS = q24_pkg::FracBitsDefault,
   parameter int WORD_BITS = q24_pkg::WordBitsDefault
) (
   input logic          clock,
   input logic          reset,
   q24_req_if.sink      req,
   q24_rsp_if.source    rsp
);

   localparam int W    = WORD_BITS;
   localparam int NB   = W + FRAC_BITS;       // dividend width
   localparam int QB   = NB + 1;              // quotient bits incl. round bit
   localparam int DS   = QB;                  // divider stages
   localparam int LAT  = DS + 3;              // decode + divider + final
   localparam int PB   = 2 * W;

   // common payload carried along the pipe
   typedef struct packed {
      logic [q24_pkg::FuncBits-1:0] func;
      logic signed [W-1:0]          a;
      logic signed [W-1:0]          b;
      logic                         neg;
      logic [W-1:0]                 mb;
   } ctl_type;

   logic advance;
   logic [LAT-1:0] vld_ff, vld_in;

   assign advance   = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 0: decode -------------------------------------
   logic signed [W-1:0] a_w, b_w;
   assign a_w = req.data.operand_a[W-1:0];
   assign b_w = req.data.operand_b[W-1:0];

   ctl_type ctl_ff [DS+1];
   logic [W-1:0] ma_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0].func <= req.data.func;
         ctl_ff[0].a    <= a_w;
         ctl_ff[0].b    <= b_w;
         ctl_ff[0].neg  <= a_w[W-1] ^ b_w[W-1];
         ctl_ff[0].mb   <= b_w[W-1] ? W'(-b_w) : W'(b_w);
         ma_ff          <= a_w[W-1] ? W'(-a_w) : W'(a_w);
      end
   end

   // ---------------- divider: one restoring step per stage ---------------
   // remainder kept W+1 bits wide, dividend bits shifted in MSB first
   logic [W:0]    rem_ff [1:DS];
   logic [NB-1:0] num_ff [1:DS];
   logic [QB-1:0] quo_ff [1:DS];

   // multiplier partial products, registered at stage 1, summed at stage 2
   localparam int HB = W / 2;
   localparam int LB = W - HB;
   logic [2*LB-1:0]  pp_ll_ff;
   logic [LB+HB-1:0] pp_lh_ff, pp_hl_ff;
   logic [2*HB-1:0]  pp_hh_ff;
   logic [PB-1:0]    prod_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ll_ff <= (2*LB)'(ma_ff[LB-1:0]) * (2*LB)'(ctl_ff[0].mb[LB-1:0]);
         pp_lh_ff <= (LB+HB)'(ma_ff[LB-1:0]) * (LB+HB)'(ctl_ff[0].mb[W-1:LB]);
         pp_hl_ff <= (LB+HB)'(ma_ff[W-1:LB]) * (LB+HB)'(ctl_ff[0].mb[LB-1:0]);
         pp_hh_ff <= (2*HB)'(ma_ff[W-1:LB]) * (2*HB)'(ctl_ff[0].mb[W-1:LB]);
         prod_ff  <= PB'(pp_ll_ff) + (PB'(pp_lh_ff) << LB) + (PB'(pp_hl_ff) << LB)
                     + (PB'(pp_hh_ff) << (2*LB));
      end
   end

   // product travels down the rest of the pipe
   logic [PB-1:0] prod_pipe_ff [DS-2];

   genvar gi;
   generate
      for (gi = 0; gi < DS; gi++) begin : g_div
         logic [W:0]    rem_cur;
         logic [NB-1:0] num_cur;
         logic [QB-1:0] quo_cur;
         logic [W:0]   trial;
         logic [W+1:0] diff;
         logic [W:0]   rem_in;
         logic [NB-1:0] num_in;
         logic [QB-1:0] quo_in;
         if (gi == 0) begin : g_seed
            // start from the decoded magnitude of a
            assign rem_cur = '0;
            assign num_cur = {ma_ff, FRAC_BITS'(0)};
            assign quo_cur = '0;
         end else begin : g_link
            assign rem_cur = rem_ff[gi];
            assign num_cur = num_ff[gi];
            assign quo_cur = quo_ff[gi];
         end
         always_comb begin
            if (gi < NB) begin
               trial  = {rem_cur[W-1:0], num_cur[NB-1]};
               num_in = {num_cur[NB-2:0], 1'b0};
            end else begin
               trial  = {rem_cur[W-1:0], 1'b0};
               num_in = num_cur;
            end
            diff = {1'b0, trial} - {2'b0, ctl_ff[gi].mb};
            if (!diff[W+1]) begin
               rem_in = diff[W:0];
               quo_in = {quo_cur[QB-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_cur[QB-2:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[gi+1]   <= rem_in;
               num_ff[gi+1]   <= num_in;
               quo_ff[gi+1]   <= quo_in;
               ctl_ff[gi+1]   <= ctl_ff[gi];
            end
         end
      end
      for (gi = 0; gi < DS - 2; gi++) begin : g_prod
         always_ff @(posedge clock) begin
            if (advance) begin
               prod_pipe_ff[gi] <= (gi == 0) ? prod_ff : prod_pipe_ff[(gi == 0) ? 0 : gi-1];
            end
         end
      end
   endgenerate

   // ---------------- stage DS+1: round, sign ------------------------------
   // quotient has one extra bit: q*2 + (2r >= d); round up when it is set.
   // Half away from zero: q += last bit.
   ctl_type         fin_ctl;
   logic [PB-1:0]   prod_last;
   logic [QB:0]     qmag;
   logic [PB:0]     pmag;
   logic signed [PB+1:0] mul_v, div_v;

   assign fin_ctl   = ctl_ff[DS];
   assign prod_last = prod_pipe_ff[DS-3];

   logic signed [PB+1:0] pre_ff;
   logic                 sat_en_ff, dz_ff, lt_ff, eq_ff, gt_ff;
   logic signed [PB+1:0] pre_in;
   logic                 sat_en_in, dz_in;
   logic signed [W:0]    a_x, b_x;

   always_comb begin
      qmag  = (QB+1)'(quo_ff[DS][QB-1:1]) + (QB+1)'(quo_ff[DS][0]);
      pmag  = (PB+1)'(prod_last >> FRAC_BITS)
              + (PB+1)'(prod_last[FRAC_BITS-1]);
      mul_v = fin_ctl.neg ? -(PB+2)'(pmag) : (PB+2)'(pmag);
      div_v = fin_ctl.neg ? -(PB+2)'(qmag) : (PB+2)'(qmag);
      a_x   = (W+1)'(fin_ctl.a);
      b_x   = (W+1)'(fin_ctl.b);
      pre_in    = '0;
      sat_en_in = 1'b0;
      dz_in     = 1'b0;
      case (fin_ctl.func)
         q24_pkg::FUNC_ADD: begin
            pre_in = (PB+2)'(a_x + b_x); sat_en_in = 1'b1;
         end
         q24_pkg::FUNC_SUB: begin
            pre_in = (PB+2)'(a_x - b_x); sat_en_in = 1'b1;
         end
         q24_pkg::FUNC_MUL: begin
            pre_in = mul_v; sat_en_in = 1'b1;
         end
         q24_pkg::FUNC_DIV: begin
            if (fin_ctl.mb == '0) begin
               dz_in = 1'b1;
            end else begin
               pre_in = div_v; sat_en_in = 1'b1;
            end
         end
         q24_pkg::FUNC_MIN: pre_in = (PB+2)'((fin_ctl.a < fin_ctl.b) ? fin_ctl.a : fin_ctl.b);
         q24_pkg::FUNC_MAX: pre_in = (PB+2)'((fin_ctl.a > fin_ctl.b) ? fin_ctl.a : fin_ctl.b);
         q24_pkg::FUNC_INC: begin
            pre_in = (PB+2)'(a_x + (W+1)'(1)); sat_en_in = 1'b1;
         end
         q24_pkg::FUNC_DEC: begin
            pre_in = (PB+2)'(a_x - (W+1)'(1)); sat_en_in = 1'b1;
         end
         q24_pkg::FUNC_TO_INT: begin
            // truncate toward zero: bias negatives before the shift
            pre_in = (PB+2)'((a_x + (fin_ctl.a[W-1] ? (W+1)'((1 << FRAC_BITS) - 1)
                                                     : (W+1)'(0))) >>> FRAC_BITS);
         end
         q24_pkg::FUNC_FROM_INT: begin
            pre_in = (PB+2)'(fin_ctl.a) <<< FRAC_BITS; sat_en_in = 1'b1;
         end
         default: pre_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pre_ff    <= pre_in;
         sat_en_ff <= sat_en_in;
         dz_ff     <= dz_in;
         lt_ff     <= fin_ctl.a < fin_ctl.b;
         eq_ff     <= fin_ctl.a == fin_ctl.b;
         gt_ff     <= fin_ctl.a > fin_ctl.b;
      end
   end

   // ---------------- last stage: saturate --------------------------------
   localparam logic signed [PB+1:0] HI = (PB+2)'((64'sd1 <<< (W-1)) - 1);
   localparam logic signed [PB+1:0] LO = -HI - 1;

   logic signed [W-1:0] res_sat;
   logic                ovf;
   always_comb begin
      ovf     = 1'b0;
      res_sat = W'(pre_ff);
      if (sat_en_ff && pre_ff > HI) begin
         ovf = 1'b1; res_sat = W'(HI);
      end else if (sat_en_ff && pre_ff < LO) begin
         ovf = 1'b1; res_sat = W'(LO);
      end
   end

   q24_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.result         <= q24_pkg::FieldBits'(res_sat);
         rsp_ff.is_less        <= lt_ff;
         rsp_ff.is_equal       <= eq_ff;
         rsp_ff.is_greater     <= gt_ff;
         rsp_ff.overflow       <= ovf;
         rsp_ff.divide_by_zero <= dz_ff;
      end
   end

   assign rsp.valid = vld_ff[LAT-1];
   assign rsp.data  = rsp_ff;

   // ---------------- assertions -------------------------------------------
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot({rsp.data.is_less, rsp.data.is_equal, rsp.data.is_greater}))
      else $error("compare flags not one-hot");
   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.divide_by_zero |-> !rsp.data.overflow && rsp.data.result == '0)
      else $error("divide by zero with nonzero result or overflow");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("pipe moved during stall");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q24.8 fixed-point ALU: a directed table of
// corner items, then random items under varying stall patterns, every result
// compared field by field against a typed expectation or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FRAC = q24_pkg::FracBitsDefault;
   localparam int WORD = q24_pkg::WordBitsDefault;
   localparam int PIPE_DEPTH = WORD + FRAC + 4;
   localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
   localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
   localparam logic signed [31:0] MIN32 = 32'sh80000000;
   // opcodes with no operation behind them
   localparam logic [3:0] FUNC_SPARE_FIRST = 4'd10;
   localparam logic [3:0] FUNC_SPARE_LAST  = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;

   q24_req_if req_ch();
   q24_rsp_if rsp_ch();

   q24_8_fixed_point_alu dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always #6 clock = ~clock;

   // results predicted for accepted items, oldest first
   q24_pkg::rsp_type pending_rsp[$];
   int      fail_count = 0;

   // idle rates in percent; hold_off forces a long receiver stall
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off      = 0;

   // directed table: expected result only where obvious, else predicted
   typedef struct {
      q24_pkg::req_type item;
      bit               typed;
      q24_pkg::rsp_type want;
   } dir_row_type;

   function automatic logic signed [63:0] saturate(input logic signed [63:0] v,
                                                   inout bit ovf);
      if (v > SAT_HI) begin
         ovf = 1'b1;
         return SAT_HI;
      end
      if (v < SAT_LO) begin
         ovf = 1'b1;
         return SAT_LO;
      end
      return v;
   endfunction

   // predict one ALU result from one request item
   function automatic q24_pkg::rsp_type alu_predict(input q24_pkg::req_type it);
      logic signed [63:0] a, b, r;
      logic [63:0]        ma, mb, p, q, n, rem;
      bit                 neg, ovf, dz;
      q24_pkg::rsp_type   o;
      a = 64'(it.operand_a);
      b = 64'(it.operand_b);
      r = '0;
      ovf = 1'b0;
      dz = 1'b0;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      case (it.func)
         q24_pkg::FUNC_ADD: r = saturate(a + b, ovf);
         q24_pkg::FUNC_SUB: r = saturate(a - b, ovf);
         q24_pkg::FUNC_MUL: begin
            p = ma * mb;
            q = (p + (64'd1 << (FRAC - 1))) >> FRAC;
            r = saturate(neg ? -$signed(q) : $signed(q), ovf);
         end
         q24_pkg::FUNC_DIV: begin
            if (b == 0) begin
               dz = 1'b1;
            end else begin
               n = ma << FRAC;
               q = n / mb;
               rem = n % mb;
               if (rem >= mb - rem) q = q + 64'd1;
               r = saturate(neg ? -$signed(q) : $signed(q), ovf);
            end
         end
         q24_pkg::FUNC_MIN: r = (a < b) ? a : b;
         q24_pkg::FUNC_MAX: r = (a > b) ? a : b;
         q24_pkg::FUNC_INC: r = saturate(a + 64'sd1, ovf);
         q24_pkg::FUNC_DEC: r = saturate(a - 64'sd1, ovf);
         q24_pkg::FUNC_TO_INT: r = a / (64'sd1 <<< FRAC);
         q24_pkg::FUNC_FROM_INT: r = saturate(a * (64'sd1 <<< FRAC), ovf);
         default: r = '0;
      endcase
      o.result         = r[31:0];
      o.is_less        = a < b;
      o.is_equal       = a == b;
      o.is_greater     = a > b;
      o.overflow       = ovf;
      o.divide_by_zero = dz;
      return o;
   endfunction

   function automatic q24_pkg::rsp_type make_rsp(input logic signed [31:0] r,
                                                 input bit lt, eq, gt, ovf, dz);
      q24_pkg::rsp_type o;
      o.result = r;
      o.is_less = lt;
      o.is_equal = eq;
      o.is_greater = gt;
      o.overflow = ovf;
      o.divide_by_zero = dz;
      return o;
   endfunction

   function automatic q24_pkg::req_type make_req(input logic [3:0] f,
                                                 input logic signed [31:0] a, b);
      q24_pkg::req_type it;
      it.func = f;
      it.operand_a = a;
      it.operand_b = b;
      return it;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // receiver: random ready, long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result", rsp_ch.data.result, '0);
         end else begin
            q24_pkg::rsp_type w, g;
            w = pending_rsp.pop_front();
            g = rsp_ch.data;
            if (g.result !== w.result) report_mismatch("result", g.result, w.result);
            if (g.is_less !== w.is_less)
               report_mismatch("is_less", 32'(g.is_less), 32'(w.is_less));
            if (g.is_equal !== w.is_equal)
               report_mismatch("is_equal", 32'(g.is_equal), 32'(w.is_equal));
            if (g.is_greater !== w.is_greater)
               report_mismatch("is_greater", 32'(g.is_greater), 32'(w.is_greater));
            if (g.overflow !== w.overflow)
               report_mismatch("overflow", 32'(g.overflow), 32'(w.overflow));
            if (g.divide_by_zero !== w.divide_by_zero)
               report_mismatch("divide_by_zero", 32'(g.divide_by_zero),
                               32'(w.divide_by_zero));
         end
      end
   end

   // push one item: idle randomly, hold valid until the handshake
   task automatic send_item(input q24_pkg::req_type it, input q24_pkg::rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= it;
      do @(posedge clock); while (!req_ch.ready);
      pending_rsp.push_back(want);
      @(negedge clock);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(5))
         0: return $urandom_range(1023) - 512;
         1: return $urandom_range(65535) - 32768;
         2: return MAX32 - $urandom_range(3);
         3: return MIN32 + $urandom_range(3);
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      dir_row_type      table_rows[$];
      q24_pkg::req_type it;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, every opcode, divide by zero, undefined opcodes
      table_rows = '{
         '{make_req(q24_pkg::FUNC_ADD, MAX32, 32'sd1), 1'b1,
           make_rsp(MAX32, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0)},
         '{make_req(q24_pkg::FUNC_SUB, MIN32, 32'sd1), 1'b1,
           make_rsp(MIN32, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0)},
         '{make_req(q24_pkg::FUNC_DIV, 32'sd256, 32'sd0), 1'b1,
           make_rsp(32'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1)},
         '{make_req(q24_pkg::FUNC_DIV, 32'sd0, 32'sd0), 1'b1,
           make_rsp(32'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1)},
         '{make_req(q24_pkg::FUNC_INC, MAX32, MAX32), 1'b1,
           make_rsp(MAX32, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0)},
         '{make_req(q24_pkg::FUNC_DEC, MIN32, MIN32), 1'b1,
           make_rsp(MIN32, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0)},
         '{make_req(FUNC_SPARE_FIRST, 32'sd5, 32'sd7), 1'b1,
           make_rsp(32'sd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
         '{make_req(FUNC_SPARE_LAST, MIN32, MAX32), 1'b1,
           make_rsp(32'sd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)},
         '{make_req(q24_pkg::FUNC_FROM_INT, MAX32, 32'sd0), 1'b1,
           make_rsp(MAX32, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0)},
         '{make_req(q24_pkg::FUNC_MUL, MIN32, MIN32), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_MUL, 32'sd384, -32'sd384), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_MUL, 32'sd1, 32'sd128), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_MUL, -32'sd1, 32'sd128), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_DIV, MIN32, -32'sd1), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_DIV, 32'sd256, 32'sd768), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_DIV, -32'sd1, 32'sd512), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_MIN, MIN32, MAX32), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_MAX, MIN32, MAX32), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_TO_INT, -32'sd255, 32'sd0), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_TO_INT, MIN32, 32'sd0), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_FROM_INT, -32'sd3, 32'sd0), 1'b0, '0},
         '{make_req(q24_pkg::FUNC_ADD, -32'sd1, -32'sd1), 1'b0, '0}
      };
      foreach (table_rows[i])
         send_item(table_rows[i].item,
                   table_rows[i].typed ? table_rows[i].want
                                       : alu_predict(table_rows[i].item));

      // three idle phases, each 150 random items
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 60 : 0;
         recv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 37 : 0;
         if (phase == 2) hold_off = 200;  // fill the pipe, stall the input
         for (int n = 0; n < 150; n++) begin
            it = make_req((n % 16 == 15)
                             ? 4'($urandom_range(FUNC_SPARE_LAST, FUNC_SPARE_FIRST))
                             : 4'($urandom_range(q24_pkg::FUNC_FROM_INT)),
                          rand_operand(), rand_operand());
            if ($urandom_range(15) == 0) it.operand_b = it.operand_a;
            send_item(it, alu_predict(it));
         end
         // pause the sender until every result is back
         drain();
      end

      repeat (PIPE_DEPTH + 10) @(negedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(2_000_000);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
